// ----- sv/tsbn_pkg.sv -----
// shared types and constants of the transfer splitter
`default_nettype none
package tsbn_pkg;

    localparam int OFS_W       = 48;
    localparam int NB_W        = 40;
    localparam int NODE_W      = 6;
    localparam int DIV_STEPS   = OFS_W;
    localparam int STEP_CNT_W  = $clog2(DIV_STEPS);
    localparam int MAX_RESULTS = 64;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS);
    localparam int S_DATA_W    = 4 * OFS_W;
    localparam int M_DATA_W    = 144;
    localparam logic [NB_W-1:0] NB_RESET = NB_W'(1048576);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_PART,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [OFS_W-1:0] quotient;
        logic [NB_W-1:0]  remainder;
        logic             done;
    } div_result_t;

endpackage
`default_nettype wire

// ----- sv/transfer_split_by_node.sv -----
// transfer splitter top level: sequencer, part walk and stream ports
//
// Cuts one transfer request into parts that never cross a node boundary.
// A request with byte_count zero is accepted and gives no result.
// Any other request is accepted and then runs through the iterative
// divider that finds the first node and the offset within it (one quotient
// bit per cycle through a 41-bit subtractor); then, for each result,
// ST_PART computes the part and ST_OUT holds it until m_tready takes it.
// A run ends with m_tlast; if it would reach node MAX_RANKS or beyond, or
// need more than 64 results, it ends with an m_tuser result of size zero.
// node_bytes is written through cfg_we/cfg_data; zero acts as one byte.
`default_nettype none
module transfer_split_by_node #(
    parameter int MAX_RANKS = 64,
    parameter int ADDR_BITS = 48
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [tsbn_pkg::NB_W-1:0]         cfg_data,
    input  wire logic                              s_tvalid,
    output      logic                              s_tready,
    // local_start, peer_base, global_start, byte_count
    input  wire logic [tsbn_pkg::S_DATA_W-1:0]     s_tdata,
    output      logic                              m_tvalid,
    input  wire logic                              m_tready,
    // node, part_local, part_remote, part_bytes, zero pad
    output      logic [tsbn_pkg::M_DATA_W-1:0]     m_tdata,
    output      logic                              m_tlast,
    // out_of_range
    output      logic                              m_tuser
);

    localparam int LOC_W = (ADDR_BITS < tsbn_pkg::OFS_W) ? ADDR_BITS : tsbn_pkg::OFS_W;
    localparam int OW    = tsbn_pkg::OFS_W;
    localparam int NW    = tsbn_pkg::NB_W;

    tsbn_pkg::state_t             state_reg, state_next;
    tsbn_pkg::div_result_t        div_res;

    logic [NW-1:0]                node_bytes_reg;
    logic [NW-1:0]                nb_reg;
    logic [OW-1:0]                quo_reg;
    logic [NW-1:0]                off_reg;
    logic [NW-1:0]                room_reg;
    logic [OW-1:0]                left_reg;
    logic [LOC_W-1:0]             local_reg;
    logic [LOC_W-1:0]             base_reg;
    logic [tsbn_pkg::RES_CNT_W-1:0] cnt_reg;
    logic                         done_reg;

    logic [tsbn_pkg::NODE_W-1:0]  o_node_reg;
    logic [OW-1:0]                o_local_reg;
    logic [OW-1:0]                o_remote_reg;
    logic [NW-1:0]                o_bytes_reg;
    logic                         o_last_reg;
    logic                         o_oor_reg;

    logic                         accept;
    logic                         div_start;
    logic                         fits_room;
    logic                         limit_hit;
    logic                         err;
    logic [NW-1:0]                sz;
    logic [63:0]                  sz_ext;
    logic [63:0]                  off_ext;
    logic [LOC_W-1:0]             remote_sum;
    logic [OW-1:0]                byte_count_in;

    assign byte_count_in = s_tdata[4*OW-1:3*OW];
    assign accept        = s_tvalid && s_tready;

    // node size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_bytes_reg <= tsbn_pkg::NB_RESET;
        end
        else if (cfg_we)
        begin
            node_bytes_reg <= cfg_data;
        end
    end

    tsbn_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (s_tdata[3*OW-1:2*OW]),
        .divisor  (nb_reg),
        .result   (div_res)
    );

    // part computation
    assign fits_room  = left_reg <= {{(OW-NW){1'b0}}, room_reg};
    assign sz         = fits_room ? left_reg[NW-1:0] : room_reg;
    assign limit_hit  = (cnt_reg == tsbn_pkg::RES_CNT_W'(tsbn_pkg::MAX_RESULTS - 1))
                        && !fits_room;
    assign err        = (quo_reg >= OW'(MAX_RANKS)) || limit_hit;
    assign sz_ext     = 64'(sz);
    assign off_ext    = 64'(off_reg);
    assign remote_sum = base_reg + off_ext[LOC_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tsbn_pkg::ST_IDLE:
            begin
                if (div_start)
                begin
                    state_next = tsbn_pkg::ST_DIV;
                end
            end
            tsbn_pkg::ST_DIV:
            begin
                if (div_res.done)
                begin
                    state_next = tsbn_pkg::ST_PART;
                end
            end
            tsbn_pkg::ST_PART:
            begin
                state_next = tsbn_pkg::ST_OUT;
            end
            tsbn_pkg::ST_OUT:
            begin
                if (m_tready)
                begin
                    state_next = done_reg ? tsbn_pkg::ST_IDLE : tsbn_pkg::ST_PART;
                end
            end
            default:
            begin
                state_next = tsbn_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        s_tready  = 1'b0;
        m_tvalid  = 1'b0;
        div_start = 1'b0;
        unique case (state_reg)
            tsbn_pkg::ST_IDLE:
            begin
                s_tready  = 1'b1;
                div_start = s_tvalid && (byte_count_in != '0);
            end
            tsbn_pkg::ST_OUT:
            begin
                m_tvalid = 1'b1;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tsbn_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // walk through the request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            local_reg <= s_tdata[LOC_W-1:0];
            base_reg  <= s_tdata[OW+LOC_W-1:OW];
            left_reg  <= byte_count_in;
            nb_reg    <= (node_bytes_reg == '0) ? NW'(1) : node_bytes_reg;
            cnt_reg   <= '0;
        end
        if (state_reg == tsbn_pkg::ST_DIV && div_res.done)
        begin
            quo_reg  <= div_res.quotient;
            off_reg  <= div_res.remainder;
            room_reg <= nb_reg - div_res.remainder;
        end
        if (state_reg == tsbn_pkg::ST_PART)
        begin
            o_local_reg <= OW'(local_reg);
            if (err)
            begin
                o_node_reg   <= '0;
                o_remote_reg <= '0;
                o_bytes_reg  <= '0;
                o_last_reg   <= 1'b1;
                o_oor_reg    <= 1'b1;
                done_reg     <= 1'b1;
            end
            else
            begin
                o_node_reg   <= quo_reg[tsbn_pkg::NODE_W-1:0];
                o_remote_reg <= OW'(remote_sum);
                o_bytes_reg  <= sz;
                o_last_reg   <= fits_room;
                o_oor_reg    <= 1'b0;
                done_reg     <= fits_room;
            end
            left_reg  <= left_reg - OW'(sz);
            local_reg <= local_reg + sz_ext[LOC_W-1:0];
            quo_reg   <= quo_reg + 1'b1;
            off_reg   <= '0;
            room_reg  <= nb_reg;
            cnt_reg   <= cnt_reg + 1'b1;
        end
    end

    assign m_tdata = {2'b00, o_bytes_reg, o_remote_reg, o_local_reg, o_node_reg};
    assign m_tlast = o_last_reg;
    assign m_tuser = o_oor_reg;

    a_err_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast && o_bytes_reg == '0)
        else $error("error result not last or not empty");

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid)
        else $error("request taken while a result is pending");

    a_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> s_tready)
        else $error("not ready after the last transaction");

endmodule
`default_nettype wire

// ----- sv/tsbn_div.sv -----
// restoring divider, one quotient bit per cycle through a shared subtractor
`default_nettype none
module tsbn_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [tsbn_pkg::OFS_W-1:0]    dividend,
    input  wire logic [tsbn_pkg::NB_W-1:0]     divisor,
    output tsbn_pkg::div_result_t              result
);

    logic                               busy_reg;
    logic                               done_reg;
    logic [tsbn_pkg::STEP_CNT_W-1:0]    cnt_reg;
    logic [tsbn_pkg::OFS_W-1:0]         quo_reg;
    logic [tsbn_pkg::NB_W-1:0]          rem_reg;
    logic [tsbn_pkg::NB_W:0]            rem_shift;
    logic [tsbn_pkg::NB_W:0]            rem_diff;
    logic                               fits;

    assign rem_shift = {rem_reg, quo_reg[tsbn_pkg::OFS_W-1]};
    assign rem_diff  = rem_shift - {1'b0, divisor};
    assign fits      = rem_shift >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == tsbn_pkg::STEP_CNT_W'(tsbn_pkg::DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[tsbn_pkg::OFS_W-2:0], fits};
            rem_reg <= fits ? rem_diff[tsbn_pkg::NB_W-1:0] : rem_shift[tsbn_pkg::NB_W-1:0];
        end
    end

    assign result.quotient  = quo_reg;
    assign result.remainder = rem_reg;
    assign result.done      = done_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && divisor != '0 |-> rem_reg < divisor)
        else $error("remainder not below divisor");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg && !busy_reg)
        else $error("done longer than one cycle");

endmodule
`default_nettype wire

// ----- tb/sv/tb_transfer_split_by_node.sv -----
// self-checking testbench for the transfer splitter with its own part predictor
`default_nettype none
module tb_transfer_split_by_node;

    localparam int NODES         = 64;
    localparam int SETTLE_CYCLES = 60;
    localparam int PHASES        = 7;
    localparam int RAND_PER_PHASE = 25;

    typedef struct packed {
        logic [tsbn_pkg::OFS_W-1:0] local_start;
        logic [tsbn_pkg::OFS_W-1:0] peer_base;
        logic [tsbn_pkg::OFS_W-1:0] global_start;
        logic [tsbn_pkg::OFS_W-1:0] byte_count;
    } split_req_t;

    typedef struct packed {
        logic [tsbn_pkg::NODE_W-1:0] node;
        logic [tsbn_pkg::OFS_W-1:0]  part_local;
        logic [tsbn_pkg::OFS_W-1:0]  part_remote;
        logic [tsbn_pkg::NB_W-1:0]   part_bytes;
        logic                        last_part;
        logic                        out_of_range;
    } split_part_t;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_NONE,
        ROW_TYPED
    } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        split_req_t  req;
        split_part_t part;
    } dir_row_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [tsbn_pkg::NB_W-1:0]      cfg_data;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [tsbn_pkg::S_DATA_W-1:0]  s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [tsbn_pkg::M_DATA_W-1:0]  m_tdata;
    logic                           m_tlast;
    logic                           m_tuser;

    split_part_t               pending_parts[$];
    logic [tsbn_pkg::NB_W-1:0] node_bytes_m;
    int                        mismatch_count;
    bit                        rx_calm;

    // node_bytes is 2^20 during the table, so the region spans 48'h400_0000 bytes
    dir_row_t dir_rows [15] = '{
        '{ROW_NONE,    '{48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'h0},
                       '0},
        '{ROW_TYPED,   '{48'h0, 48'h0, 48'h0, 48'd1},
                       '{6'd0, 48'h0, 48'h0, 40'd1, 1'b1, 1'b0}},
        '{ROW_TYPED,   '{48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'h0, 48'd1},
                       '{6'd0, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 40'd1, 1'b1, 1'b0}},
        '{ROW_TYPED,   '{48'h1234_5678_9ABC, 48'hFFFF_FFFF_FFFF, 48'h400_0000, 48'd1},
                       '{6'd0, 48'h1234_5678_9ABC, 48'h0, 40'd0, 1'b1, 1'b1}},
        '{ROW_TYPED,   '{48'hFFFF_FFFF_FFFF, 48'h0, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF},
                       '{6'd0, 48'hFFFF_FFFF_FFFF, 48'h0, 40'd0, 1'b1, 1'b1}},
        '{ROW_TYPED,   '{48'h0, 48'h10, 48'h3FF_FFFF, 48'd1},
                       '{6'd63, 48'h0, 48'h10_000F, 40'd1, 1'b1, 1'b0}},
        '{ROW_TYPED,   '{48'h5, 48'h0, 48'h10_0000, 48'h10_0000},
                       '{6'd1, 48'h5, 48'h0, 40'h10_0000, 1'b1, 1'b0}},
        '{ROW_PREDICT, '{48'h100, 48'h200, 48'hF_FFF0, 48'h20}, '0},
        '{ROW_PREDICT, '{48'h0, 48'h0, 48'h0, 48'h400_0000}, '0},
        '{ROW_PREDICT, '{48'h0, 48'h0, 48'h0, 48'h400_0001}, '0},
        '{ROW_PREDICT, '{48'h7, 48'h9, 48'h1, 48'h3FF_FFFF}, '0},
        '{ROW_PREDICT, '{48'hFFFF_FFFF_FFF0, 48'hFFFF_FFFF_FF00, 48'h1F_FF00, 48'h300}, '0},
        '{ROW_PREDICT, '{48'h40, 48'h80, 48'h3FF_FF00, 48'h200}, '0},
        '{ROW_PREDICT, '{48'h0, 48'h0, 48'h0, 48'hFFFF_FFFF_FFFF}, '0},
        '{ROW_NONE,    '{48'h0, 48'h0, 48'h0, 48'h0}, '0}
    };

    transfer_split_by_node #(
        .MAX_RANKS(NODES),
        .ADDR_BITS(tsbn_pkg::OFS_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .m_tuser(m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #60_000_000;
        $display("** transfer_split_by_node: FAILED **");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // walks one request across the node boundaries and queues its parts
    function automatic void split_transfer(input split_req_t rq);
        logic [63:0]                nb;
        logic [63:0]                goff;
        logic [63:0]                left;
        logic [63:0]                nd;
        logic [63:0]                ofs;
        logic [63:0]                room;
        logic [63:0]                sz;
        logic [tsbn_pkg::OFS_W-1:0] loc;
        split_part_t                p;
        int                         cnt;
        nb   = (node_bytes_m == '0) ? 64'd1 : 64'(node_bytes_m);
        goff = 64'(rq.global_start);
        left = 64'(rq.byte_count);
        loc  = rq.local_start;
        cnt  = 0;
        while (left != 0)
        begin
            nd   = goff / nb;
            ofs  = goff % nb;
            room = nb - ofs;
            sz   = (left < room) ? left : room;
            if (nd >= 64'(NODES) || (cnt == tsbn_pkg::MAX_RESULTS - 1 && left > sz))
            begin
                p = '{'0, loc, '0, '0, 1'b1, 1'b1};
                pending_parts.push_back(p);
                break;
            end
            left -= sz;
            p.node         = nd[tsbn_pkg::NODE_W-1:0];
            p.part_local   = loc;
            p.part_remote  = rq.peer_base + ofs[tsbn_pkg::OFS_W-1:0];
            p.part_bytes   = sz[tsbn_pkg::NB_W-1:0];
            p.last_part    = (left == 0);
            p.out_of_range = 1'b0;
            pending_parts.push_back(p);
            cnt++;
            loc  = loc + sz[tsbn_pkg::OFS_W-1:0];
            goff = goff + sz;
        end
    endfunction

    // mostly requests that stay inside the region, some that run off it, some noise
    function automatic split_req_t make_request();
        logic [63:0] nb;
        logic [63:0] region;
        logic [63:0] g;
        logic [63:0] c;
        split_req_t  rq;
        int          pick;
        nb     = (node_bytes_m == '0) ? 64'd1 : 64'(node_bytes_m);
        region = nb * 64'(NODES);
        rq.local_start = tsbn_pkg::OFS_W'(rand64());
        rq.peer_base   = tsbn_pkg::OFS_W'(rand64());
        if ($urandom_range(0, 3) == 0)
            rq.local_start = 48'hFFFF_FFFF_FFFF - tsbn_pkg::OFS_W'($urandom_range(0, 255));
        if ($urandom_range(0, 3) == 0)
            rq.peer_base = 48'hFFFF_FFFF_FFFF - tsbn_pkg::OFS_W'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            rq.global_start = tsbn_pkg::OFS_W'(rand64());
            rq.byte_count   = tsbn_pkg::OFS_W'(rand64() >> $urandom_range(0, 47));
            return rq;
        end
        g = rand64() % region;
        if ($urandom_range(0, 9) < 3)
        begin
            g = nb * 64'($urandom_range(0, NODES - 1)) + 64'($urandom_range(0, 3));
            if ($urandom_range(0, 1) == 1 && g >= 64'd8)
                g = g - 64'($urandom_range(1, 8));
        end
        pick = $urandom_range(0, 99);
        if (pick < 40)
            c = rand64() % (nb * 64'd3) + 64'd1;
        else if (pick < 60)
            c = 64'($urandom_range(1, 16));
        else if (pick < 75)
            c = region - g;
        else if (pick < 85)
            c = region - g + 64'($urandom_range(1, 8));
        else if (pick < 95)
            c = 64'd0;
        else
            c = rand64() % region + 64'd1;
        rq.global_start = g[tsbn_pkg::OFS_W-1:0];
        rq.byte_count   = c[tsbn_pkg::OFS_W-1:0];
        return rq;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    task automatic send_request(input split_req_t rq, input bit calm);
        int gap;
        int pick;
        gap  = 0;
        pick = $urandom_range(0, 99);
        if (!calm)
        begin
            if (pick >= 95)
                gap = $urandom_range(15, 40);
            else if (pick >= 65)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {rq.byte_count, rq.global_start, rq.peer_base, rq.local_start};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        while (pending_parts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_node_bytes(input logic [tsbn_pkg::NB_W-1:0] value);
        wait_results_done();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        node_bytes_m = value;
    endtask

    // result side: random stalls, some phases always ready
    initial
    begin
        int stall_left;
        int pick;
        stall_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_calm)
                m_tready <= 1'b1;
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    m_tready <= 1'b1;
                else if (pick < 96)
                begin
                    m_tready <= 1'b0;
                    stall_left = $urandom_range(0, 3);
                end
                else
                begin
                    m_tready <= 1'b0;
                    stall_left = $urandom_range(10, 30);
                end
            end
        end
    end

    // compare each result transaction with the oldest queued part
    always @(posedge clk)
    begin : part_check
        split_part_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_parts.size() == 0)
                report_mismatch("unexpected result, part_local", 64'(m_tdata[53:6]), '0);
            else
            begin
                want = pending_parts.pop_front();
                if (m_tdata[5:0] !== want.node)
                    report_mismatch("node", 64'(m_tdata[5:0]), 64'(want.node));
                if (m_tdata[53:6] !== want.part_local)
                    report_mismatch("part_local", 64'(m_tdata[53:6]), 64'(want.part_local));
                if (m_tdata[101:54] !== want.part_remote)
                    report_mismatch("part_remote", 64'(m_tdata[101:54]),
                                    64'(want.part_remote));
                if (m_tdata[141:102] !== want.part_bytes)
                    report_mismatch("part_bytes", 64'(m_tdata[141:102]),
                                    64'(want.part_bytes));
                if (m_tlast !== want.last_part)
                    report_mismatch("last_part", 64'(m_tlast), 64'(want.last_part));
                if (m_tuser !== want.out_of_range)
                    report_mismatch("out_of_range", 64'(m_tuser), 64'(want.out_of_range));
            end
        end
    end

    initial
    begin
        logic [tsbn_pkg::NB_W-1:0] phase_nb [PHASES];
        split_req_t                rq;
        bit                        calm;
        rst_n    <= 1'b0;
        cfg_we   <= 1'b0;
        cfg_data <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        rx_calm        = 1'b0;
        mismatch_count = 0;
        node_bytes_m   = tsbn_pkg::NB_RESET;
        phase_nb = '{tsbn_pkg::NB_RESET, 40'd0, 40'd1, 40'hFF_FFFF_FFFF, 40'd7, 40'd4096,
                     tsbn_pkg::NB_W'(rand64() >> $urandom_range(0, 40))};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph > 0)
                write_node_bytes(phase_nb[ph]);
            calm    = (ph == 2 || ph == 5);
            rx_calm = (ph == 3 || ph == 5);
            if (ph == 0)
            begin
                foreach (dir_rows[k])
                begin
                    send_request(dir_rows[k].req, 1'b0);
                    case (dir_rows[k].kind)
                        ROW_PREDICT: split_transfer(dir_rows[k].req);
                        ROW_TYPED:   pending_parts.push_back(dir_rows[k].part);
                        ROW_NONE:    ;
                    endcase
                end
            end
            for (int i = 0; i < RAND_PER_PHASE; i++)
            begin
                rq = make_request();
                send_request(rq, calm);
                split_transfer(rq);
                // let the block run dry now and then before the next transaction
                if (i == 12 || $urandom_range(0, 24) == 0)
                    wait_results_done();
            end
        end

        wait_results_done();
        if (mismatch_count == 0)
            $display("** transfer_split_by_node: PASSED **");
        else
            $display("** transfer_split_by_node: FAILED **");
        $finish;
    end

endmodule
`default_nettype wire

// ----- filelist.f -----
sv/tsbn_pkg.sv
sv/tsbn_div.sv
sv/transfer_split_by_node.sv
tb/sv/tb_transfer_split_by_node.sv
